/* hw/rtl/ugd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ugd_pkg
// Types, constants and bandwidth tables shared by the uplink grant decoder.
// ----------------------------------------------------------------------------
package ugd_pkg;

    // Configuration register indexes
    localparam logic [3:0] CFG_IDX_BANDWIDTH = 4'd0;
    localparam logic [3:0] CFG_IDX_TDD       = 4'd1;

    // Highest meaningful bandwidth code (100 resource blocks)
    localparam logic [2:0] BW_CODE_MAX = 3'd5;

    // Hopping field width that selects two bits
    localparam logic [1:0] HOP_LEN_WIDE = 2'd2;

    // Reciprocal scaling for the constant divide
    localparam int RECIP_SHIFT = 16;

    typedef logic [2:0]  code_t;
    typedef logic [12:0] riv_t;

    // Grant fields that travel beside the RIV math
    typedef struct packed {
        logic       format0;
        logic       hopping_flag;
        logic [1:0] hopping_bits;
        logic       riv_invalid;
        logic [4:0] mcs;
        logic       ndi;
        logic [1:0] tpc;
        logic [2:0] cyclic_shift;
        logic [1:0] ul_index_or_dai;
        logic       cqi_request;
    } ugd_fields_t;

    // After unpack
    typedef struct packed {
        ugd_fields_t fields;
        code_t       code;
        riv_t        riv;
    } ugd_item_t;

    // After the reciprocal multiply
    typedef struct packed {
        ugd_fields_t fields;
        code_t       code;
        riv_t        riv;
        logic [26:0] prod;
    } ugd_prod_t;

    // After the back multiply and subtract
    typedef struct packed {
        ugd_fields_t fields;
        code_t       code;
        logic [6:0]  quot;
        logic [7:0]  rem;
    } ugd_est_t;

    // Corrected quotient and remainder
    typedef struct packed {
        ugd_fields_t fields;
        code_t       code;
        logic [6:0]  quot;
        logic [6:0]  rmd;
    } ugd_div_t;

    // Resource blocks per bandwidth code
    function automatic logic [6:0] bw_nrb(input code_t code);
        logic [6:0] n;
        case (code)
            3'd0:    n = 7'd6;
            3'd1:    n = 7'd15;
            3'd2:    n = 7'd25;
            3'd3:    n = 7'd50;
            3'd4:    n = 7'd75;
            default: n = 7'd100;
        endcase
        return n;
    endfunction

    // RIV field width including hopping bits
    function automatic logic [3:0] bw_riv_len(input code_t code);
        logic [3:0] w;
        case (code)
            3'd0:    w = 4'd5;
            3'd1:    w = 4'd7;
            3'd2:    w = 4'd9;
            3'd3:    w = 4'd11;
            3'd4:    w = 4'd12;
            default: w = 4'd13;
        endcase
        return w;
    endfunction

    // Hopping selector width
    function automatic logic [1:0] bw_hop_len(input code_t code);
        logic [1:0] w;
        case (code)
            3'd0, 3'd1, 3'd2: w = 2'd1;
            default:          w = 2'd2;
        endcase
        return w;
    endfunction

    // floor(2^16 / N)
    function automatic logic [13:0] bw_recip(input code_t code);
        logic [13:0] r;
        case (code)
            3'd0:    r = 14'd10922;
            3'd1:    r = 14'd4369;
            3'd2:    r = 14'd2621;
            3'd3:    r = 14'd1310;
            3'd4:    r = 14'd873;
            default: r = 14'd655;
        endcase
        return r;
    endfunction

    // Largest legal RIV, N(N+1)/2 - 1
    function automatic riv_t bw_riv_max(input code_t code);
        riv_t m;
        case (code)
            3'd0:    m = 13'd20;
            3'd1:    m = 13'd119;
            3'd2:    m = 13'd324;
            3'd3:    m = 13'd1274;
            3'd4:    m = 13'd2849;
            default: m = 13'd5049;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/ugd_unpack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ugd_unpack
// First pipeline stage: splits the grant word into fields, extracts the RIV
// and checks it against the bandwidth limit.
// ----------------------------------------------------------------------------
module ugd_unpack (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [31:0]         dci_word,
    input  wire  ugd_pkg::code_t code,
    input  wire                 tdd_mode,
    output logic                out_valid,
    input  wire                 out_ready,
    output ugd_pkg::ugd_item_t  out_item
);
    import ugd_pkg::*;

    logic        valid_reg;
    ugd_item_t   item_reg;
    ugd_item_t   item_next;

    logic [29:0] body;
    logic [29:0] riv_shift;
    logic [29:0] tail;
    logic [3:0]  rw;
    logic [1:0]  hw;
    logic [3:0]  riv_len;
    logic [12:0] riv_mask;
    riv_t        riv_raw;
    logic        hop;

    // Field extraction
    always_comb begin
        body      = dci_word[29:0];
        hop       = dci_word[30];
        rw        = bw_riv_len(code);
        hw        = bw_hop_len(code);
        riv_shift = body >> (5'd30 - {1'b0, rw});
        riv_len   = hop ? (rw - {2'b00, hw}) : rw;
        riv_mask  = 13'((14'd1 << riv_len) - 14'd1);
        riv_raw   = riv_shift[12:0] & riv_mask;
        tail      = body << rw;

        item_next                        = '0;
        item_next.code                   = code;
        item_next.fields.format0         = 1'b1;
        item_next.fields.hopping_flag    = hop;
        if (hop) begin
            item_next.fields.hopping_bits = (hw == HOP_LEN_WIDE) ? body[29:28]
                                                                 : {1'b0, body[29]};
        end
        item_next.fields.mcs             = tail[29:25];
        item_next.fields.ndi             = tail[24];
        item_next.fields.tpc             = tail[23:22];
        item_next.fields.cyclic_shift    = tail[21:19];
        if (tdd_mode) begin
            item_next.fields.ul_index_or_dai = tail[18:17];
            item_next.fields.cqi_request     = tail[16];
        end else begin
            item_next.fields.cqi_request     = tail[18];
        end

        // Out-of-range RIV goes through the divider as zero
        if (riv_raw > bw_riv_max(code)) begin
            item_next.fields.riv_invalid = 1'b1;
        end else begin
            item_next.riv = riv_raw;
        end

        // Not format 0: all fields and the RIV zero
        if (dci_word[31]) begin
            item_next.fields = '0;
            item_next.riv    = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

/* hw/rtl/ugd_riv_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ugd_riv_div
// Three-stage divide of the RIV by N: reciprocal multiply, back multiply and
// subtract, then a single compare-subtract correction.
// ----------------------------------------------------------------------------
module ugd_riv_div (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  ugd_pkg::ugd_item_t in_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output ugd_pkg::ugd_div_t   out_div
);
    import ugd_pkg::*;

    logic       s2_valid_reg;
    logic       s3_valid_reg;
    logic       s4_valid_reg;
    ugd_prod_t  s2_reg;
    ugd_prod_t  s2_next;
    ugd_est_t   s3_reg;
    ugd_est_t   s3_next;
    ugd_div_t   s4_reg;
    ugd_div_t   s4_next;
    logic       s2_ready;
    logic       s3_ready;
    logic       s4_ready;

    logic [6:0]  s3_quot;
    logic [13:0] s3_back;
    logic [13:0] s3_diff;
    logic [7:0]  s4_n;
    logic [7:0]  s4_sub;

    // Per-stage ready, stall ripples back from the output
    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    // Stage 2: quotient estimate by reciprocal
    always_comb begin
        s2_next.fields = in_item.fields;
        s2_next.code   = in_item.code;
        s2_next.riv    = in_item.riv;
        s2_next.prod   = {14'd0, in_item.riv} * {13'd0, bw_recip(in_item.code)};
    end

    // Stage 3: remainder of the estimate, below 2N
    always_comb begin
        s3_quot        = s2_reg.prod[RECIP_SHIFT +: 7];
        s3_back        = {7'd0, s3_quot} * {7'd0, bw_nrb(s2_reg.code)};
        s3_diff        = {1'b0, s2_reg.riv} - s3_back;
        s3_next.fields = s2_reg.fields;
        s3_next.code   = s2_reg.code;
        s3_next.quot   = s3_quot;
        s3_next.rem    = s3_diff[7:0];
    end

    // Stage 4: correct estimate that came out one low
    always_comb begin
        s4_n           = {1'b0, bw_nrb(s3_reg.code)};
        s4_sub         = s3_reg.rem - s4_n;
        s4_next.fields = s3_reg.fields;
        s4_next.code   = s3_reg.code;
        if (s3_reg.rem >= s4_n) begin
            s4_next.quot = s3_reg.quot + 7'd1;
            s4_next.rmd  = s4_sub[6:0];
        end else begin
            s4_next.quot = s3_reg.quot;
            s4_next.rmd  = s3_reg.rem[6:0];
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s2_ready) begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (in_valid && s2_ready) begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && s3_ready) begin
            s3_reg <= s3_next;
        end
        if (s3_valid_reg && s4_ready) begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_div   = s4_reg;

`ifndef SYNTHESIS
    // Estimate is never more than one below the true quotient
    a_est_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> ({1'b0, s3_reg.rem} < {1'b0, bw_nrb(s3_reg.code), 1'b0}))
        else $error("divider estimate remainder out of range");

    a_rmd_below_n: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> (s4_reg.rmd < bw_nrb(s4_reg.code)))
        else $error("corrected remainder not below N");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> (s4_reg.quot <= bw_nrb(s4_reg.code)))
        else $error("quotient above N");
`endif

endmodule
`default_nettype wire

/* hw/rtl/ul_grant_dci0_decoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ul_grant_dci0_decoder_top
// Uplink grant (format 0) decoder: unpacks a 32-bit grant word and turns the
// RIV into start block and block count.
// ----------------------------------------------------------------------------
//  Channel   Dir   Signals                               Content
//  s_        in    s_valid / s_ready / s_dci_word        grant word
//  m_        out   m_valid / m_ready / m_*               decoded fields
//  cfg_      in    cfg_valid / cfg_ready / cfg_index,    register write
//                  cfg_data
//
//  One word per cycle sustained while m_ready stays high; registered in order:
//  unpack, reciprocal multiply, back multiply, correction, output register.
//  Synchronous active-low reset empties the pipe; bandwidth code resets
//  to 100 blocks, TDD off.
//  Each stage holds while the one after it is full and stalled, so empty
//  stages keep filling while a result waits on m_ready.
// ----------------------------------------------------------------------------
module ul_grant_dci0_decoder_top (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [3:0]  cfg_index,
    input  wire  [7:0]  cfg_data,
    // grant words
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_dci_word,
    // decoded results
    output logic        m_valid,
    input  wire         m_ready,
    output logic        m_format0,
    output logic        m_hopping_flag,
    output logic [1:0]  m_hopping_bits,
    output logic [6:0]  m_rb_start,
    output logic [6:0]  m_num_rb,
    output logic        m_riv_invalid,
    output logic [4:0]  m_mcs,
    output logic        m_ndi,
    output logic [1:0]  m_tpc,
    output logic [2:0]  m_cyclic_shift,
    output logic [1:0]  m_ul_index_or_dai,
    output logic        m_cqi_request
);
    import ugd_pkg::*;

    code_t       bw_code_reg;
    logic        tdd_mode_reg;
    code_t       code_sat;

    logic        up_valid;
    logic        up_ready;
    ugd_item_t   up_item;
    logic        div_valid;
    logic        div_ready;
    ugd_div_t    div_res;

    logic        out_valid_reg;
    ugd_fields_t out_fields_reg;
    ugd_fields_t out_fields_next;
    logic [6:0]  rb_start_reg;
    logic [6:0]  rb_start_next;
    logic [6:0]  num_rb_reg;
    logic [6:0]  num_rb_next;

    logic [6:0]  n;
    logic [7:0]  fold_sum;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_code_reg  <= BW_CODE_MAX;
            tdd_mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IDX_BANDWIDTH) begin
                bw_code_reg <= cfg_data[2:0];
            end else if (cfg_index == CFG_IDX_TDD) begin
                tdd_mode_reg <= cfg_data[0];
            end
        end
    end

    // Unused codes behave as 100 blocks
    assign code_sat = (bw_code_reg > BW_CODE_MAX) ? BW_CODE_MAX : bw_code_reg;

    ugd_unpack u_unpack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .dci_word  (s_dci_word),
        .code      (code_sat),
        .tdd_mode  (tdd_mode_reg),
        .out_valid (up_valid),
        .out_ready (up_ready),
        .out_item  (up_item)
    );

    ugd_riv_div u_riv_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (up_valid),
        .in_ready  (up_ready),
        .in_item   (up_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_div   (div_res)
    );

    // Output stage: mirrored RIV form when a + b + 1 > N
    always_comb begin
        n               = bw_nrb(div_res.code);
        fold_sum        = {1'b0, div_res.quot} + {1'b0, div_res.rmd} + 8'd1;
        out_fields_next = div_res.fields;
        if (fold_sum > {1'b0, n}) begin
            rb_start_next = n - 7'd1 - div_res.rmd;
            num_rb_next   = n - div_res.quot + 7'd1;
        end else begin
            rb_start_next = div_res.rmd;
            num_rb_next   = div_res.quot + 7'd1;
        end
        if (!div_res.fields.format0 || div_res.fields.riv_invalid) begin
            rb_start_next = '0;
            num_rb_next   = '0;
        end
    end

    assign div_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (div_ready) begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid && div_ready) begin
            out_fields_reg <= out_fields_next;
            rb_start_reg   <= rb_start_next;
            num_rb_reg     <= num_rb_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_format0         = out_fields_reg.format0;
    assign m_hopping_flag    = out_fields_reg.hopping_flag;
    assign m_hopping_bits    = out_fields_reg.hopping_bits;
    assign m_rb_start        = rb_start_reg;
    assign m_num_rb          = num_rb_reg;
    assign m_riv_invalid     = out_fields_reg.riv_invalid;
    assign m_mcs             = out_fields_reg.mcs;
    assign m_ndi             = out_fields_reg.ndi;
    assign m_tpc             = out_fields_reg.tpc;
    assign m_cyclic_shift    = out_fields_reg.cyclic_shift;
    assign m_ul_index_or_dai = out_fields_reg.ul_index_or_dai;
    assign m_cqi_request     = out_fields_reg.cqi_request;

`ifndef SYNTHESIS
    // A valid allocation fits inside the configured bandwidth
    a_alloc_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_format0 && !m_riv_invalid) |->
        ((m_num_rb != 7'd0) &&
         (({1'b0, m_rb_start} + {1'b0, m_num_rb}) <= {1'b0, bw_nrb(code_sat)})))
        else $error("decoded allocation outside bandwidth");

    a_not_format0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_format0) |->
        (!m_hopping_flag && (m_mcs == 5'd0) && (m_num_rb == 7'd0) && !m_riv_invalid))
        else $error("non format 0 result carries fields");

    a_invalid_no_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_riv_invalid) |-> ((m_rb_start == 7'd0) && (m_num_rb == 7'd0)))
        else $error("invalid RIV produced an allocation");
`endif

endmodule
`default_nettype wire
